/* rtl/orf_pkg.sv */
// Shared types and constants for the overwriting ring FIFO.
`default_nettype none

package orf_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned MAX_DATA_W     = 64;

  localparam int unsigned REQ_W      = 3;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OCC_W      = 6;
  localparam int unsigned RING_LEN_W = 7;

  localparam logic [RING_LEN_W-1:0] RING_LEN_RST = 7'd64;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_RING_LEN = '0;

  // command queue between front and back, power of two
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH    = 3'd0,
    REQ_POP     = 3'd1,
    REQ_PEEK    = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_EXTRACT = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_EXTRACT = 3'd4,
    OP_NOP     = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [WORD_W-1:0]  push_data;
    logic [COUNT_W-1:0] max_count;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   read_data;
    logic                data_valid;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
    logic                last;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] max_count;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/overwriting_ring_fifo.sv */
// Top level of the overwriting ring FIFO: register port, front and back.
//
// Use: requests (push, pop, peek, clear, extract) enter on the in_* valid/ready
// channel; results leave on the out_* channel, each carrying data, status,
// occupancy and a last flag. The ring length register sits at byte address 0
// of the APB-style port and must be written only while the block is idle (the
// block itself does not enforce this); a write empties the ring.
// An accepted request is held in the command queue until the engine takes it
// and loads its result into the result register.
// Throughput: one result per cycle unless out_ready_i holds a result. Push,
// pop, peek, clear and no-op give one result each; an extract of n words gives
// n results, one slot memory read each; an extract that yields nothing gives one.
// Reset: the ring is empty, the ring length is 64 (clamped to DEPTH), the
// command queue and the result register are empty. Slot contents are not
// cleared; a slot is only read after it was written.
// Stall: while a valid result waits on a low out_ready_i, the register holds,
// the engine stops and the two-entry command queue takes requests until full.
`default_nettype none

module overwriting_ring_fifo #(
  parameter int unsigned DEPTH      = orf_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = orf_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [orf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [orf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [orf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  orf_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output orf_pkg::out_item_t             out_data_o
);
  import orf_pkg::*;

  logic [RING_LEN_W-1:0] ring_len_q;
  logic                  reg_hit, cfg_wr;
  logic                  cmd_valid, cmd_ready;
  cmd_t                  cmd;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_RING_LEN);
  assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? APB_DATA_W'(ring_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_len_q <= RING_LEN_RST;
    end else if (cfg_wr) begin
      ring_len_q <= pwdata[RING_LEN_W-1:0];
    end
  end

  orf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  orf_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ring_len_i  (ring_len_q),
    .cfg_wr_i    (cfg_wr),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/orf_front.sv */
// Request decode and short command queue in front of the ring engine.
`default_nettype none

module orf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  orf_pkg::in_item_t in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output orf_pkg::cmd_t     cmd_o
);
  import orf_pkg::*;

  localparam logic [Q_PTR_W:0] FILL_FULL = (Q_PTR_W+1)'(Q_DEPTH);

  cmd_t               cmd_in;
  cmd_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_PTR_W:0]   fill_q, fill_d;
  logic               push, pop;

  // classify; unknown codes become a no-op
  always_comb begin
    cmd_in.data      = in_data_i.push_data;
    cmd_in.max_count = in_data_i.max_count;
    unique case (in_data_i.req_type)
      REQ_PUSH:    cmd_in.op = OP_PUSH;
      REQ_POP:     cmd_in.op = OP_POP;
      REQ_PEEK:    cmd_in.op = OP_PEEK;
      REQ_CLEAR:   cmd_in.op = OP_CLEAR;
      REQ_EXTRACT: cmd_in.op = OP_EXTRACT;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != FILL_FULL);
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];

  assign push = in_valid_i & in_ready_o;
  assign pop  = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/orf_back.sv */
// Ring engine: slot memory, ring indices, burst sequencing and result register.
`default_nettype none

module orf_back #(
  parameter int unsigned DEPTH      = orf_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = orf_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [orf_pkg::RING_LEN_W-1:0] ring_len_i,
  input  logic                           cfg_wr_i,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  orf_pkg::cmd_t                  cmd_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output orf_pkg::out_item_t             out_data_o
);
  import orf_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d, wr_nxt;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               burst_q, burst_d;
  logic [COUNT_W-1:0] left_q, left_d;
  logic [CNT_W-1:0]   len;
  logic [COUNT_W-1:0] count_w, avail;

  logic               fire, done, mem_we, mem_re;
  logic               res_dv, res_last;
  status_e            res_st;

  logic               out_valid_q, out_valid_d;
  logic               dv_q, last_q;
  status_e            st_q;
  logic [OCC_W-1:0]   occ_q;

  logic [MAX_DATA_W-1:0] wr_wide, rd_wide;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [CNT_W-1:0] l);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    return (nxt == l) ? '0 : nxt[IDX_W-1:0];
  endfunction

  // clamp ring length into 2..DEPTH
  always_comb begin
    if (ring_len_i < RING_LEN_W'(2)) begin
      len = CNT_W'(2);
    end else if (ring_len_i > RING_LEN_W'(DEPTH)) begin
      len = CNT_W'(DEPTH);
    end else begin
      len = ring_len_i[CNT_W-1:0];
    end
  end

  assign fire    = cmd_valid_i & (~out_valid_q | out_ready_i);
  assign count_w = COUNT_W'(count_q);
  assign wr_nxt  = adv(wr_idx_q, len);
  assign avail   = burst_q ? left_q
                 : ((cmd_i.max_count < count_w) ? cmd_i.max_count : count_w);

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    burst_d  = burst_q;
    left_d   = left_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_dv   = 1'b0;
    res_st   = ST_OK;
    res_last = 1'b1;
    done     = 1'b1;
    case (cmd_i.op)
      OP_PUSH: begin
        mem_we   = 1'b1;
        wr_idx_d = wr_nxt;
        // write index caught the head: drop the oldest word
        if (wr_nxt == rd_idx_q) begin
          rd_idx_d = adv(rd_idx_q, len);
          res_st   = ST_OVERFLOW;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (count_q == '0) begin
          res_st = ST_EMPTY;
        end else begin
          mem_re = 1'b1;
          res_dv = 1'b1;
          if (cmd_i.op == OP_POP) begin
            rd_idx_d = adv(rd_idx_q, len);
            count_d  = count_q - CNT_W'(1);
          end
        end
      end
      OP_CLEAR: begin
        wr_idx_d = '0;
        rd_idx_d = '0;
        count_d  = '0;
      end
      OP_EXTRACT: begin
        if (avail == '0) begin
          res_st = (count_q == '0) ? ST_EMPTY : ST_OK;
        end else begin
          mem_re   = 1'b1;
          res_dv   = 1'b1;
          rd_idx_d = adv(rd_idx_q, len);
          count_d  = count_q - CNT_W'(1);
          res_last = (avail == COUNT_W'(1));
          done     = res_last;
          burst_d  = ~res_last;
          left_d   = avail - COUNT_W'(1);
        end
      end
      default: ;
    endcase

    // hold everything unless the command executes this cycle or a ring length write empties the ring
    if (!fire) begin
      wr_idx_d = wr_idx_q;
      rd_idx_d = rd_idx_q;
      count_d  = count_q;
      burst_d  = burst_q;
      left_d   = left_q;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
    end
    if (cfg_wr_i) begin
      wr_idx_d = '0;
      rd_idx_d = '0;
      count_d  = '0;
      burst_d  = 1'b0;
    end
  end

  assign cmd_ready_o = fire & done;

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      count_q     <= '0;
      burst_q     <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      count_q     <= count_d;
      burst_q     <= burst_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      dv_q   <= res_dv;
      st_q   <= res_st;
      occ_q  <= OCC_W'(count_d);
      last_q <= res_last;
    end
  end

  assign wr_wide = MAX_DATA_W'(cmd_i.data);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx_q] <= wr_wide[DATA_WIDTH-1:0];
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  assign rd_wide = MAX_DATA_W'(rdata_q);

  assign out_valid_o = out_valid_q;

  always_comb begin
    out_data_o.read_data  = dv_q ? rd_wide[WORD_W-1:0] : '0;
    out_data_o.data_valid = dv_q;
    out_data_o.status     = st_q;
    out_data_o.occupancy  = occ_q;
    out_data_o.last       = last_q;
  end

endmodule

`default_nettype wire

/* rtl/orf_checker.sv */
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module orf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input orf_pkg::out_item_t out_data_o
);
  import orf_pkg::*;

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.data_valid |-> out_data_o.read_data == '0)
    else $error("read_data nonzero without data_valid");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY
      |-> !out_data_o.data_valid && out_data_o.occupancy == '0 && out_data_o.last)
    else $error("empty result carries data or occupancy");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OVERFLOW
      |-> !out_data_o.data_valid && out_data_o.last)
    else $error("overflow flagged on a non-push result");

  // only extract bursts produce non-final results, each with a word
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last
      |-> out_data_o.data_valid && out_data_o.status == ST_OK)
    else $error("non-final result without data");

endmodule

bind overwriting_ring_fifo orf_checker u_orf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
